// File: design/fcsg_pkg.sv
// Package for the five channel sound generator.
// Holds command codes, frame timing constants, lookup tables and shared types.
// No dependencies.
package fcsg_pkg;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;
    localparam logic [1:0] CMD_DMA    = 2'd3;

    localparam logic [12:0] FRAME_FIRST = 13'd7457;
    localparam logic [12:0] FRAME_MID   = 13'd7458;
    localparam logic [12:0] FRAME_LAST  = 13'd7452;
    localparam logic [2:0]  FRAME_PRE   = 3'd7;

    localparam logic [6:0]  DMC_TOP     = 7'd125;
    localparam logic [13:0] SWEEP_LIMIT = 14'h07FF;
    localparam logic [15:0] DMC_WRAP    = 16'h8000;
    localparam logic [15:0] ADDR_TOP    = 16'hFFFF;
    localparam logic [1:0]  DMC_BASE    = 2'b11;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 40;

    typedef struct packed {
        logic       start;
        logic [3:0] divider;
        logic [3:0] decay;
    } t_env;

    typedef struct packed {
        logic       sample_valid;
        logic [4:0] pulse_level;
        logic [7:0] tnd_level;
        logic [7:0] read_data;
        logic       dma_request;
        logic [15:0] dma_address;
        logic       irq_line;
        logic       bad_access;
    } t_result;

    function automatic logic [7:0] len_lookup(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0: v = 8'd10;   5'd1: v = 8'd254;  5'd2: v = 8'd20;   5'd3: v = 8'd2;
            5'd4: v = 8'd40;   5'd5: v = 8'd4;    5'd6: v = 8'd80;   5'd7: v = 8'd6;
            5'd8: v = 8'd160;  5'd9: v = 8'd8;    5'd10: v = 8'd60;  5'd11: v = 8'd10;
            5'd12: v = 8'd14;  5'd13: v = 8'd12;  5'd14: v = 8'd26;  5'd15: v = 8'd14;
            5'd16: v = 8'd12;  5'd17: v = 8'd16;  5'd18: v = 8'd24;  5'd19: v = 8'd18;
            5'd20: v = 8'd48;  5'd21: v = 8'd20;  5'd22: v = 8'd96;  5'd23: v = 8'd22;
            5'd24: v = 8'd192; 5'd25: v = 8'd24;  5'd26: v = 8'd72;  5'd27: v = 8'd26;
            5'd28: v = 8'd16;  5'd29: v = 8'd28;  5'd30: v = 8'd32;  5'd31: v = 8'd30;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] noise_lookup(input logic [3:0] idx);
        logic [11:0] v;
        case (idx)
            4'd0: v = 12'd4;     4'd1: v = 12'd8;     4'd2: v = 12'd16;    4'd3: v = 12'd32;
            4'd4: v = 12'd64;    4'd5: v = 12'd96;    4'd6: v = 12'd128;   4'd7: v = 12'd160;
            4'd8: v = 12'd202;   4'd9: v = 12'd254;   4'd10: v = 12'd380;  4'd11: v = 12'd508;
            4'd12: v = 12'd762;  4'd13: v = 12'd1016; 4'd14: v = 12'd2034; 4'd15: v = 12'd4068;
            default: v = 12'd0;
        endcase
        return v;
    endfunction

    function automatic logic [8:0] dmc_lookup(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0: v = 9'd428;  4'd1: v = 9'd380;  4'd2: v = 9'd340;  4'd3: v = 9'd320;
            4'd4: v = 9'd286;  4'd5: v = 9'd254;  4'd6: v = 9'd226;  4'd7: v = 9'd214;
            4'd8: v = 9'd190;  4'd9: v = 9'd160;  4'd10: v = 9'd142; 4'd11: v = 9'd128;
            4'd12: v = 9'd106; 4'd13: v = 9'd84;  4'd14: v = 9'd72;  4'd15: v = 9'd54;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] duty_lookup(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0: v = 8'h02;
            2'd1: v = 8'h06;
            2'd2: v = 8'h1E;
            2'd3: v = 8'hF9;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] tri_lookup(input logic [4:0] step);
        return step[4] ? step[3:0] : ~step[3:0];
    endfunction

    // Quarter-frame envelope clock.
    function automatic t_env env_clock(input t_env e, input logic [7:0] ctl);
        t_env r;
        r = e;
        if (e.start) begin
            r.start   = 1'b0;
            r.decay   = 4'd15;
            r.divider = ctl[3:0];
        end else if (e.divider == 4'd0) begin
            r.divider = ctl[3:0];
            if (e.decay != 4'd0) r.decay = e.decay - 4'd1;
            else if (ctl[5]) r.decay = 4'd15;
        end else begin
            r.divider = e.divider - 4'd1;
        end
        return r;
    endfunction

endpackage

// File: design/fcsg_core.sv
// Channel state and per-item update logic of the sound generator.
// One item is applied per enabled cycle; the result is combinational.
// Depends on fcsg_pkg.
module fcsg_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [1:0]         i_cmd,
    input  logic [4:0]         i_off,
    input  logic [7:0]         i_data,
    input  logic [4:0]         i_mute,
    output fcsg_pkg::t_result  o_res
);

    localparam logic [4:0] OFF_SWEEP1 = 5'd1,  OFF_LO1 = 5'd2,  OFF_HI1 = 5'd3;
    localparam logic [4:0] OFF_SWEEP2 = 5'd5,  OFF_LO2 = 5'd6,  OFF_HI2 = 5'd7;
    localparam logic [4:0] OFF_LIN = 5'd8, OFF_TLO = 5'd10, OFF_THI = 5'd11;
    localparam logic [4:0] OFF_NPER = 5'd14, OFF_NLEN = 5'd15;
    localparam logic [4:0] OFF_DCTL = 5'd16, OFF_DLVL = 5'd17, OFF_DADR = 5'd18;
    localparam logic [4:0] OFF_DLEN = 5'd19, OFF_GAP1 = 5'd20, OFF_ENA = 5'd21;
    localparam logic [4:0] OFF_GAP2 = 5'd22, OFF_FRAME = 5'd23;

    logic [7:0]  r_reg [24];      logic [7:0]  n_reg [24];
    fcsg_pkg::t_env r_env [3];    fcsg_pkg::t_env n_env [3];
    logic [7:0]  r_len [4];       logic [7:0]  n_len [4];
    logic [11:0] r_pper [2];      logic [11:0] n_pper [2];
    logic [12:0] r_ptim [2];      logic [12:0] n_ptim [2];
    logic [2:0]  r_pstep [2];     logic [2:0]  n_pstep [2];
    logic [2:0]  r_swcnt [2];     logic [2:0]  n_swcnt [2];
    logic        r_swrel [2];     logic        n_swrel [2];
    logic        r_swsil [2];     logic        n_swsil [2];
    logic [14:0] r_lfsr, n_lfsr;
    logic [11:0] r_nper, n_nper, r_ntim, n_ntim;
    logic [11:0] r_tper, n_tper, r_ttim, n_ttim;
    logic [4:0]  r_tstep, n_tstep;
    logic [6:0]  r_lin, n_lin, r_linld, n_linld;
    logic        r_linrel, n_linrel;
    logic [8:0]  r_dper, n_dper, r_dtim, n_dtim;
    logic [7:0]  r_dshift, n_dshift;
    logic [3:0]  r_dbits, n_dbits;
    logic [6:0]  r_dlvl, n_dlvl;
    logic [15:0] r_dadr, n_dadr, r_dstart, n_dstart;
    logic [11:0] r_dleft, n_dleft, r_dtotal, n_dtotal;
    logic [12:0] r_fcnt, n_fcnt, r_ftgt, n_ftgt;
    logic [2:0]  r_fstep, n_fstep;
    logic        r_firq, n_firq, r_dirq, n_dirq, r_await, n_await;

    logic        q, h, five, do_emit, do_bit, p;
    logic [13:0] fnext;
    logic [2:0]  sp1, nn, fs;
    logic [7:0]  ctl, sw;
    logic [11:0] adj;
    logic signed [13:0] tgt;
    logic [4:0]  pvol [2];
    logic [3:0]  nvol;
    logic [7:0]  tnd;
    logic        fb;
    fcsg_pkg::t_result res;

    always_comb begin
        n_reg = r_reg;  n_env = r_env;  n_len = r_len;  n_pper = r_pper;
        n_ptim = r_ptim; n_pstep = r_pstep; n_swcnt = r_swcnt; n_swrel = r_swrel;
        n_swsil = r_swsil; n_lfsr = r_lfsr; n_nper = r_nper; n_ntim = r_ntim;
        n_tper = r_tper; n_ttim = r_ttim; n_tstep = r_tstep; n_lin = r_lin;
        n_linld = r_linld; n_linrel = r_linrel; n_dper = r_dper; n_dtim = r_dtim;
        n_dshift = r_dshift; n_dbits = r_dbits; n_dlvl = r_dlvl; n_dadr = r_dadr;
        n_dstart = r_dstart; n_dleft = r_dleft; n_dtotal = r_dtotal;
        n_fcnt = r_fcnt; n_ftgt = r_ftgt; n_fstep = r_fstep;
        n_firq = r_firq; n_dirq = r_dirq; n_await = r_await;
        res = '0; q = 1'b0; h = 1'b0; five = 1'b0; do_emit = 1'b0; do_bit = 1'b0;
        fnext = '0; sp1 = '0; nn = '0; fs = '0; ctl = '0; sw = '0; adj = '0;
        tgt = '0; fb = 1'b0; p = i_off[2];

        if (r_await) begin
            if (i_cmd == fcsg_pkg::CMD_DMA) begin
                // take the fetched byte
                n_await  = 1'b0;
                n_dshift = i_data;
                n_dleft  = r_dleft - 12'd1;
                if (n_dleft == 12'd0) begin
                    if (r_reg[16][6]) begin
                        n_dleft = r_dtotal;
                        n_dadr  = r_dstart;
                    end
                    if (r_reg[16][7]) n_dirq = 1'b1;
                end else begin
                    n_dadr = (r_dadr == fcsg_pkg::ADDR_TOP) ? fcsg_pkg::DMC_WRAP
                                                            : r_dadr + 16'd1;
                end
                n_dbits = 4'd8;
                do_bit  = 1'b1;
                do_emit = 1'b1;
            end else begin
                res.dma_request = 1'b1;
                res.dma_address = r_dadr;
            end
        end else begin
            case (i_cmd)
                fcsg_pkg::CMD_TICK: begin
                    // frame sequencer
                    fnext = {1'b0, r_fcnt} + 14'd1;
                    if (fnext >= {1'b0, r_ftgt}) begin
                        five  = r_reg[23][7];
                        sp1   = (r_fstep == fcsg_pkg::FRAME_PRE) ? 3'd0 : r_fstep + 3'd1;
                        nn    = five ? 3'd5 : 3'd4;
                        fs    = (sp1 >= nn) ? sp1 - nn : sp1;
                        fnext = fnext - {1'b0, r_ftgt};
                        n_fstep = fs;
                        h = (fs == 3'd0) || (fs == 3'd2);
                        if (five) begin
                            n_ftgt = (fs == 3'd0) ? fcsg_pkg::FRAME_FIRST :
                                     (fs == 3'd4) ? fcsg_pkg::FRAME_LAST : fcsg_pkg::FRAME_MID;
                            q = (fs != 3'd4);
                        end else begin
                            n_ftgt = (fs[1:0] == 2'd0) ? fcsg_pkg::FRAME_FIRST
                                                       : fcsg_pkg::FRAME_MID;
                            q = 1'b1;
                            if (fs == 3'd0 && !r_reg[23][6]) n_firq = 1'b1;
                        end
                    end
                    n_fcnt = fnext[12:0];

                    for (int i = 0; i < 2; i++) begin
                        ctl = r_reg[4*i];
                        sw  = r_reg[4*i+1];
                        if (q) n_env[i] = fcsg_pkg::env_clock(r_env[i], ctl);
                        if (h) begin
                            if (!ctl[5] && r_len[i] != 8'd0) n_len[i] = r_len[i] - 8'd1;
                            if (r_swcnt[i] == 3'd0) begin
                                adj = r_pper[i] >> sw[2:0];
                                if (sw[3])
                                    tgt = $signed({2'b00, r_pper[i]}) - $signed({2'b00, adj})
                                          - ((i == 0) ? 14'sd1 : 14'sd0);
                                else
                                    tgt = $signed({2'b00, r_pper[i]}) + $signed({2'b00, adj});
                                if (tgt < 0) tgt = '0;
                                n_swsil[i] = (tgt >= $signed(fcsg_pkg::SWEEP_LIMIT));
                                if (sw[7] && !n_swsil[i] && sw[2:0] != 3'd0)
                                    n_pper[i] = tgt[11:0];
                                n_swcnt[i] = sw[6:4];
                                n_swrel[i] = 1'b0;
                            end else if (r_swrel[i]) begin
                                n_swcnt[i] = sw[6:4];
                                n_swrel[i] = 1'b0;
                            end else begin
                                n_swcnt[i] = r_swcnt[i] - 3'd1;
                            end
                        end
                        if (r_ptim[i] <= 13'd1) begin
                            n_ptim[i] = {n_pper[i], 1'b0};
                            if (n_len[i] != 8'd0) n_pstep[i] = r_pstep[i] + 3'd1;
                        end else begin
                            n_ptim[i] = r_ptim[i] - 13'd1;
                        end
                    end

                    // noise
                    if (q) n_env[2] = fcsg_pkg::env_clock(r_env[2], r_reg[12]);
                    if (h && !r_reg[12][5] && r_len[3] != 8'd0) n_len[3] = r_len[3] - 8'd1;
                    if (r_ntim <= 12'd1) begin
                        fb = r_lfsr[0] ^ (r_reg[14][7] ? r_lfsr[6] : r_lfsr[1]);
                        n_ntim = r_nper;
                        n_lfsr = {fb, r_lfsr[14:1]};
                    end else begin
                        n_ntim = r_ntim - 12'd1;
                    end

                    // triangle
                    if (q) begin
                        if (r_linrel) n_lin = r_linld;
                        else if (r_lin != 7'd0) n_lin = r_lin - 7'd1;
                        if (!r_reg[8][7]) n_linrel = 1'b0;
                    end
                    if (h && !r_reg[8][7] && r_len[2] != 8'd0) n_len[2] = r_len[2] - 8'd1;
                    if (r_ttim <= 12'd1) begin
                        n_ttim = r_tper;
                        if (n_len[2] != 8'd0 && n_lin != 7'd0 && r_tper > 12'd7)
                            n_tstep = r_tstep + 5'd1;
                    end else begin
                        n_ttim = r_ttim - 12'd1;
                    end

                    // delta sample channel
                    do_emit = 1'b1;
                    if (r_dtim <= 9'd1) begin
                        n_dtim = r_dper;
                        if (r_dbits == 4'd0 && r_dleft != 12'd0) begin
                            n_await = 1'b1;
                            res.dma_request = 1'b1;
                            res.dma_address = r_dadr;
                            do_emit = 1'b0;
                        end else begin
                            do_bit = 1'b1;
                        end
                    end else begin
                        n_dtim = r_dtim - 9'd1;
                    end
                end
                fcsg_pkg::CMD_WRITE: begin
                    if (i_off == OFF_GAP1 || i_off == OFF_GAP2 || i_off > OFF_FRAME) begin
                        res.bad_access = 1'b1;
                    end else begin
                        n_reg[i_off] = i_data;
                        case (i_off)
                            OFF_SWEEP1, OFF_SWEEP2: begin
                                n_swcnt[p] = 3'd0;
                                n_swrel[p] = 1'b1;
                                n_swsil[p] = 1'b0;
                            end
                            OFF_LO1, OFF_LO2: begin
                                n_pper[p] = {1'b0, n_reg[{2'b00, p, 2'b11}][2:0],
                                             n_reg[{2'b00, p, 2'b10}]} + 12'd1;
                            end
                            OFF_HI1, OFF_HI2: begin
                                n_pper[p] = {1'b0, n_reg[{2'b00, p, 2'b11}][2:0],
                                             n_reg[{2'b00, p, 2'b10}]} + 12'd1;
                                n_env[p].start = 1'b1;
                                n_pstep[p] = 3'd0;
                                if (r_reg[21][p]) n_len[p] = fcsg_pkg::len_lookup(i_data[7:3]);
                            end
                            OFF_LIN: begin
                                n_linld = i_data[6:0];
                                if (i_data[7]) n_linrel = 1'b1;
                            end
                            OFF_TLO, OFF_THI: begin
                                n_tper = {1'b0, n_reg[11][2:0], n_reg[10]} + 12'd1;
                                if (i_off == OFF_THI) begin
                                    if (r_reg[21][2])
                                        n_len[2] = fcsg_pkg::len_lookup(i_data[7:3]);
                                    n_linrel = 1'b1;
                                end
                            end
                            OFF_NPER: n_nper = fcsg_pkg::noise_lookup(i_data[3:0]);
                            OFF_NLEN: begin
                                n_env[2].start = 1'b1;
                                if (r_reg[21][3]) n_len[3] = fcsg_pkg::len_lookup(i_data[7:3]);
                            end
                            OFF_DCTL: begin
                                n_dper = fcsg_pkg::dmc_lookup(i_data[3:0]);
                                if (!i_data[7]) n_dirq = 1'b0;
                            end
                            OFF_DLVL: n_dlvl = i_data[6:0];
                            OFF_DADR: begin
                                n_dstart = {fcsg_pkg::DMC_BASE, i_data, 6'd0};
                                n_dadr   = {fcsg_pkg::DMC_BASE, i_data, 6'd0};
                            end
                            OFF_DLEN: begin
                                n_dtotal = {i_data, 4'd0} + 12'd1;
                                if (r_reg[21][4]) n_dleft = n_dtotal;
                            end
                            OFF_ENA: begin
                                for (int i = 0; i < 4; i++)
                                    if (!i_data[i]) n_len[i] = 8'd0;
                                if (!i_data[4]) begin
                                    n_dleft = 12'd0;
                                end else if (r_dleft == 12'd0) begin
                                    n_dleft = r_dtotal;
                                    n_dadr  = r_dstart;
                                end
                                n_dirq = 1'b0;
                            end
                            OFF_FRAME: begin
                                if (i_data[6]) n_firq = 1'b0;
                                n_fstep = fcsg_pkg::FRAME_PRE;
                                n_ftgt  = r_fcnt[0] ? 13'd3 : 13'd4;
                                n_fcnt  = 13'd0;
                            end
                            default: ;
                        endcase
                    end
                end
                fcsg_pkg::CMD_STATUS: begin
                    res.read_data = {r_dirq, r_firq, 1'b0, r_dleft != 12'd0,
                                     r_len[3] != 8'd0, r_len[2] != 8'd0,
                                     r_len[1] != 8'd0, r_len[0] != 8'd0};
                    n_firq = 1'b0;
                end
                default: ;  // stray DMA return
            endcase
        end

        // shift out one sample bit
        if (do_bit && n_dbits != 4'd0) begin
            if (n_dshift[0]) begin
                if (n_dlvl <= fcsg_pkg::DMC_TOP) n_dlvl = n_dlvl + 7'd2;
            end else if (n_dlvl >= 7'd2) begin
                n_dlvl = n_dlvl - 7'd2;
            end
            n_dshift = n_dshift >> 1;
            n_dbits  = n_dbits - 4'd1;
        end

        // mix
        for (int i = 0; i < 2; i++) begin
            pvol[i] = '0;
            if (fcsg_pkg::duty_lookup(n_reg[4*i][7:6])[n_pstep[i]] && !n_swsil[i] &&
                n_len[i] != 8'd0 && n_pper[i] >= 12'd8 && !i_mute[i])
                pvol[i] = {1'b0, n_reg[4*i][4] ? n_reg[4*i][3:0] : n_env[i].decay};
        end
        nvol = n_reg[12][4] ? n_reg[12][3:0] : n_env[2].decay;
        tnd = {1'b0, n_dlvl} & {8{!i_mute[4]}};
        if (!i_mute[2]) tnd = tnd + 8'(3 * fcsg_pkg::tri_lookup(n_tstep));
        if (n_len[3] != 8'd0 && !n_lfsr[0] && !i_mute[3]) tnd = tnd + {3'd0, nvol, 1'b0};
        if (do_emit) begin
            res.sample_valid = 1'b1;
            res.pulse_level  = pvol[0] + pvol[1];
            res.tnd_level    = tnd;
        end
        res.irq_line = n_firq | n_dirq;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 24; i++) r_reg[i] <= '0;
            for (int i = 0; i < 3; i++) r_env[i] <= '0;
            for (int i = 0; i < 4; i++) r_len[i] <= '0;
            for (int i = 0; i < 2; i++) begin
                r_pper[i] <= '0; r_ptim[i] <= '0; r_pstep[i] <= '0;
                r_swcnt[i] <= '0; r_swrel[i] <= 1'b0; r_swsil[i] <= 1'b0;
            end
            r_lfsr <= 15'd1; r_nper <= '0; r_ntim <= '0;
            r_tper <= '0; r_ttim <= '0; r_tstep <= '0;
            r_lin <= '0; r_linld <= '0; r_linrel <= 1'b0;
            r_dper <= '0; r_dtim <= '0; r_dshift <= 8'd1; r_dbits <= '0;
            r_dlvl <= '0; r_dadr <= '0; r_dstart <= '0; r_dleft <= '0; r_dtotal <= '0;
            r_fcnt <= '0; r_ftgt <= fcsg_pkg::FRAME_FIRST; r_fstep <= '0;
            r_firq <= 1'b0; r_dirq <= 1'b0; r_await <= 1'b0;
        end else if (i_en) begin
            r_reg <= n_reg; r_env <= n_env; r_len <= n_len;
            r_pper <= n_pper; r_ptim <= n_ptim; r_pstep <= n_pstep;
            r_swcnt <= n_swcnt; r_swrel <= n_swrel; r_swsil <= n_swsil;
            r_lfsr <= n_lfsr; r_nper <= n_nper; r_ntim <= n_ntim;
            r_tper <= n_tper; r_ttim <= n_ttim; r_tstep <= n_tstep;
            r_lin <= n_lin; r_linld <= n_linld; r_linrel <= n_linrel;
            r_dper <= n_dper; r_dtim <= n_dtim; r_dshift <= n_dshift; r_dbits <= n_dbits;
            r_dlvl <= n_dlvl; r_dadr <= n_dadr; r_dstart <= n_dstart;
            r_dleft <= n_dleft; r_dtotal <= n_dtotal;
            r_fcnt <= n_fcnt; r_ftgt <= n_ftgt; r_fstep <= n_fstep;
            r_firq <= n_firq; r_dirq <= n_dirq; r_await <= n_await;
        end
    end

endmodule

// File: design/five_channel_sound_generator_unit.sv
// Five channel sound generator: input register, channel core, result register, APB.
// Depends on fcsg_pkg and fcsg_core.
//
// Usage: each input transaction carries a command in tuser (tick, register write,
// status read, DMA byte return) with offset and data in tdata. Every input
// transaction yields exactly one output transaction. A tick gives the pulse and
// triangle/noise/DMC sums, or a DMA request; the sender must then supply a DMA
// return transaction, which completes the tick.
// An accepted transaction passes the input register, then the result register;
// one transaction per cycle is sustained while the receiver does not stall, set by
// the core's single update pass. The input register accepts while empty even if the
// result register waits, and holds when the receiver stalls with both stages full.
// Reset (synchronous, active low) resets all channel state, empties both stages
// and clears the mute mask. The mute mask is written over APB at address 0.
module five_channel_sound_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // reg_offset[4:0], data[12:5]
    input  logic [1:0]  i_s_axis_tuser,   // cmd[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // pulse_level[4:0], tnd_level[12:5],
                                          // read_data[20:13], dma_address[36:21],
                                          // irq_line[37], bad_access[38]
    output logic [1:0]  o_m_axis_tuser,   // sample_valid[0], dma_request[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_in_valid;
    logic [15:0] r_in_data;
    logic [1:0]  r_in_cmd;
    logic        r_out_valid;
    fcsg_pkg::t_result r_out;
    fcsg_pkg::t_result res;
    logic [4:0]  r_mute;
    logic        advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign pready          = 1'b1;
    assign prdata          = paddr[2] ? 32'd0 : {27'd0, r_mute};

    fcsg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_cmd   (r_in_cmd),
        .i_off   (r_in_data[4:0]),
        .i_data  (r_in_data[12:5]),
        .i_mute  (r_mute),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mute      <= '0;
        end else begin
            if (o_s_axis_tready) r_in_valid <= i_s_axis_tvalid;
            if (advance) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
            if (psel && penable && pwrite && !paddr[2]) r_mute <= pwdata[4:0];
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_cmd  <= i_s_axis_tuser;
        end
        if (advance) r_out <= res;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_out.dma_request, r_out.sample_valid};
    assign o_m_axis_tdata  = {1'b0, r_out.bad_access, r_out.irq_line, r_out.dma_address,
                              r_out.read_data, r_out.tnd_level, r_out.pulse_level};

endmodule

// File: design/fcsg_checker.sv
// Port-level checks for the sound generator, bound to the top level.
// Depends on five_channel_sound_generator_unit.
module fcsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    a_kind_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("sample and dma request together");

    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[4:0] <= 5'd30)
        else $error("pulse level out of range");

    a_tnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[12:5] <= 8'd202)
        else $error("tnd level out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind five_channel_sound_generator_unit fcsg_checker u_fcsg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
